// ===== rtl/core/amcp_pkg.sv =====
`timescale 1ns / 1ps

package amcp_pkg;

  localparam int VALUE_CHAR_LIMIT_DEF = 12;
  localparam int QUEUE_DEPTH_DEF      = 2;

  localparam int AXIS_W = 26;
  localparam int MAG_W  = 40;
  localparam int CAND_W = 10;
  localparam int KW_CNT = 10;
  localparam int KW_MAXLEN = 15;

  localparam logic [AXIS_W-1:0] AXIS_MASK_RESET = 26'h3800000;
  localparam logic [MAG_W-1:0]  MAG_MAX         = 40'd999999999999;
  localparam logic [CAND_W-1:0] CAND_ALL        = 10'b11_1111_1111;
  localparam logic [CAND_W-1:0] CMD_BITS        = 10'b00_0001_1110;
  localparam logic [CAND_W-1:0] PAR_BITS        = 10'b11_1111_1110;

  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // keywords, right-justified: last character in the low byte
  localparam logic [8*KW_MAXLEN-1:0] CMD_WORD [KW_CNT] = '{
    "", "ADD", "GET", "SET", "RESET", "", "", "", "", ""
  };
  localparam logic [3:0] CMD_LEN [KW_CNT] = '{
    4'd0, 4'd3, 4'd3, 4'd3, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };
  localparam logic [8*KW_MAXLEN-1:0] PAR_WORD [KW_CNT] = '{
    "", "ALL", "TARGETPOSITION", "CURRENTPOSITION", "MINSPS", "MAXSPS",
    "CURRENTSPS", "ACCSPS", "ACCPRESCALER", "STATUS"
  };
  localparam logic [3:0] PAR_LEN [KW_CNT] = '{
    4'd0, 4'd3, 4'd14, 4'd15, 4'd6, 4'd6, 4'd10, 4'd6, 4'd12, 4'd6
  };

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [AXIS_W-1:0] axis_letter_mask;
  } cfg_word_t;

  typedef struct packed {
    logic [2:0]       command_code;
    logic             axis_found;
    logic [7:0]       axis_letter;
    logic [3:0]       parameter_code;
    logic [MAG_W-1:0] value_magnitude;
    logic             value_negative;
  } request_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_dot;
    logic       is_colon;
    logic       is_minus;
    logic       is_plus;
    logic       axis_ok;
  } item_t;

  typedef struct packed {
    logic [CAND_W-1:0] match;
    logic [3:0]        count;
    logic [3:0]        last;
    logic [3:0]        last_len;
  } narrow_t;

  // keep the candidates that fit ch at position idx
  function automatic narrow_t word_narrow(input logic par, input logic [CAND_W-1:0] mask,
                                          input logic [3:0] idx, input logic [7:0] ch);
    narrow_t n;
    logic [8*KW_MAXLEN-1:0] w;
    logic [3:0] len;
    int sh;
    n = '0;
    for (int k = 1; k < KW_CNT; k++) begin
      w   = par ? PAR_WORD[k] : CMD_WORD[k];
      len = par ? PAR_LEN[k] : CMD_LEN[k];
      if (mask[k] && idx < len) begin
        sh = 8 * (int'(len) - 1 - int'(idx));
        if (w[sh +: 8] == ch) begin
          n.match[k] = 1'b1;
          n.count    = n.count + 4'd1;
          n.last     = 4'(k);
          n.last_len = len;
        end
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/amcp_chan_if.sv =====
`timescale 1ns / 1ps

interface amcp_chan_if #(parameter type data_t = logic [7:0]) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/amcp_front.sv =====
`timescale 1ns / 1ps

module amcp_front (
  input  logic            clk,
  input  logic            rst,
  amcp_chan_if.sink       rx,
  amcp_chan_if.sink       cfg,
  input  logic            full,
  output logic            push,
  output amcp_pkg::item_t item
);

  logic [amcp_pkg::AXIS_W-1:0] axis_mask;
  logic [7:0] ch;
  logic [7:0] letter_off;
  logic [7:0] digit_off;
  logic       is_letter;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mask <= amcp_pkg::AXIS_MASK_RESET;
    end else if (cfg.valid) begin
      axis_mask <= cfg.data.axis_letter_mask;
    end
  end

  assign rx.ready = !full;
  assign push     = rx.valid && !full;

  always_comb begin
    ch = rx.data.rx_byte;
    // fold to upper case
    if (ch >= amcp_pkg::CH_LOWER_A && ch <= amcp_pkg::CH_LOWER_Z) begin
      ch = ch - amcp_pkg::CASE_OFFSET;
    end
    letter_off = ch - amcp_pkg::CH_UPPER_A;
    digit_off  = ch - amcp_pkg::CH_ZERO;
    is_letter  = ch >= amcp_pkg::CH_UPPER_A && ch <= amcp_pkg::CH_UPPER_Z;

    item.ch       = ch;
    item.digit    = digit_off[3:0];
    item.is_digit = ch >= amcp_pkg::CH_ZERO && ch <= amcp_pkg::CH_NINE;
    item.is_dot   = ch == amcp_pkg::CH_DOT;
    item.is_colon = ch == amcp_pkg::CH_COLON;
    item.is_minus = ch == amcp_pkg::CH_MINUS;
    item.is_plus  = ch == amcp_pkg::CH_PLUS;
    item.axis_ok  = is_letter && axis_mask[letter_off[4:0]];
  end

endmodule

// ===== rtl/core/amcp_queue.sv =====
`timescale 1ns / 1ps

module amcp_queue #(
  parameter int DEPTH = amcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  amcp_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output amcp_pkg::item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  amcp_pkg::item_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/amcp_back.sv =====
`timescale 1ns / 1ps

module amcp_back #(
  parameter int VALUE_CHAR_LIMIT = amcp_pkg::VALUE_CHAR_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  amcp_pkg::item_t head,
  output logic            pop,
  amcp_chan_if.source     req
);

  localparam int POS_W = ($clog2(VALUE_CHAR_LIMIT + 2) > 4) ? $clog2(VALUE_CHAR_LIMIT + 2) : 4;

  localparam logic [1:0] FLD_CMD   = 2'd0;
  localparam logic [1:0] FLD_AXIS  = 2'd1;
  localparam logic [1:0] FLD_PARAM = 2'd2;
  localparam logic [1:0] FLD_VALUE = 2'd3;

  typedef struct packed {
    logic [1:0]                  field;
    logic [POS_W-1:0]            pos;
    logic [amcp_pkg::CAND_W-1:0] mask;
    logic [2:0]                  cmd;
    logic [7:0]                  axis;
    logic [3:0]                  param;
    logic [amcp_pkg::MAG_W-1:0]  acc;
    logic                        neg;
  } parse_t;

  localparam parse_t ST_RESET = '{
    field: FLD_CMD, pos: '0, mask: amcp_pkg::CAND_ALL, cmd: '0, axis: '0,
    param: '0, acc: '0, neg: 1'b0
  };

  parse_t                      st;
  parse_t                      st_next;
  parse_t                      restart;
  amcp_pkg::narrow_t           n_cur;
  amcp_pkg::narrow_t           n_par;
  amcp_pkg::narrow_t           n_new;
  logic [amcp_pkg::CAND_W-1:0] mask_eff;
  logic [amcp_pkg::MAG_W+3:0]  acc_mul;
  logic [amcp_pkg::MAG_W-1:0]  acc_sat;
  logic                        emit;
  logic                        step;
  logic                        out_valid;
  amcp_pkg::request_t          out_data;

  assign step = head_valid && (!out_valid || req.ready);
  assign pop  = step;

  assign req.valid = out_valid;
  assign req.data  = out_data;

  // acc * 10 + digit, saturated
  assign acc_mul = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0}
                 + {{amcp_pkg::MAG_W{1'b0}}, head.digit};
  assign acc_sat = (acc_mul > {4'd0, amcp_pkg::MAG_MAX}) ? amcp_pkg::MAG_MAX
                 : acc_mul[amcp_pkg::MAG_W-1:0];

  assign mask_eff = (st.pos == '0) ? amcp_pkg::CAND_ALL : st.mask;
  assign n_cur = amcp_pkg::word_narrow(1'b0, mask_eff, st.pos[3:0], head.ch);
  assign n_par = amcp_pkg::word_narrow(1'b1, st.mask, 4'(st.pos[3:0] - 4'd1), head.ch);
  assign n_new = amcp_pkg::word_narrow(1'b0, amcp_pkg::CAND_ALL, 4'd0, head.ch);

  // fresh request with this byte taken as the first command character
  always_comb begin
    restart       = ST_RESET;
    restart.mask  = (amcp_pkg::CAND_ALL & ~amcp_pkg::CMD_BITS) | n_new.match;
    if (n_new.count != 4'd0) begin
      if (n_new.count == 4'd1 && n_new.last_len == 4'd1) begin
        restart.cmd   = n_new.last[2:0];
        restart.field = FLD_AXIS;
      end else begin
        restart.pos = POS_W'(1);
      end
    end
  end

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    case (st.field)
      FLD_CMD: begin
        if (n_cur.count != 4'd0) begin
          st_next.mask = (mask_eff & ~amcp_pkg::CMD_BITS) | n_cur.match;
          if (n_cur.count == 4'd1 && n_cur.last_len == 4'(st.pos[3:0] + 4'd1)) begin
            st_next.cmd   = n_cur.last[2:0];
            st_next.field = FLD_AXIS;
            st_next.pos   = '0;
          end else begin
            st_next.pos = st.pos + POS_W'(1);
          end
        end else if (st.pos != '0) begin
          // broken keyword: retry the byte as a command start
          st_next = restart;
        end else begin
          st_next.mask = mask_eff & ~amcp_pkg::CMD_BITS;
        end
      end
      FLD_AXIS: begin
        if (head.axis_ok) begin
          st_next.axis  = head.ch;
          st_next.field = FLD_PARAM;
          st_next.pos   = '0;
        end else begin
          emit    = 1'b1;
          st_next = restart;
        end
      end
      FLD_PARAM: begin
        if (st.pos == '0) begin
          if (head.is_dot) begin
            st_next.mask = amcp_pkg::CAND_ALL;
            st_next.pos  = POS_W'(1);
          end else if (head.is_colon) begin
            st_next.field = FLD_VALUE;
            st_next.pos   = POS_W'(1);
          end else begin
            emit    = 1'b1;
            st_next = restart;
          end
        end else if (n_par.count == 4'd0) begin
          // parameter abandoned: examine the byte as the value start
          if (head.is_colon) begin
            st_next.field = FLD_VALUE;
            st_next.pos   = POS_W'(1);
          end else begin
            emit    = 1'b1;
            st_next = restart;
          end
        end else begin
          st_next.mask = (st.mask & ~amcp_pkg::PAR_BITS) | n_par.match;
          if (n_par.count == 4'd1 && n_par.last_len == st.pos[3:0]) begin
            st_next.param = n_par.last;
            st_next.field = FLD_VALUE;
            st_next.pos   = '0;
          end else begin
            st_next.pos = st.pos + POS_W'(1);
          end
        end
      end
      default: begin
        if (st.pos == '0) begin
          if (head.is_colon) begin
            st_next.pos = POS_W'(1);
          end else begin
            emit    = 1'b1;
            st_next = restart;
          end
        end else if (st.pos == POS_W'(1) && (head.is_minus || head.is_plus)) begin
          st_next.neg = st.neg | head.is_minus;
          st_next.pos = POS_W'(2);
        end else if (head.is_digit && st.pos <= POS_W'(VALUE_CHAR_LIMIT)) begin
          st_next.acc = acc_sat;
          st_next.pos = st.pos + POS_W'(1);
        end else begin
          emit    = 1'b1;
          st_next = restart;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        st <= st_next;
      end
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (req.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_data.command_code    <= st.cmd;
      out_data.axis_found      <= st.axis != 8'd0;
      out_data.axis_letter     <= st.axis;
      out_data.parameter_code  <= st.param;
      out_data.value_magnitude <= st.acc;
      out_data.value_negative  <= st.neg;
    end
  end

endmodule

// ===== rtl/core/ascii_motion_command_parser_top.sv =====
`timescale 1ns / 1ps
// Output: a request is registered as the byte that ends it leaves the queue.
// Throughput: one byte per cycle unless req stalls, set by the keyword compare
// and accumulator update in the parser stage; a small queue decouples intake from it.
// Reset: synchronous rst clears parser state, queue and output valid, and loads
// the axis mask with 0x3800000 (X, Y, Z). No clearing pass.

module ascii_motion_command_parser_top #(
  parameter int VALUE_CHAR_LIMIT = amcp_pkg::VALUE_CHAR_LIMIT_DEF,
  parameter int QUEUE_DEPTH      = amcp_pkg::QUEUE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  amcp_chan_if.sink   rx,
  amcp_chan_if.sink   cfg,
  amcp_chan_if.source req
);

  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  amcp_pkg::item_t in_item;
  amcp_pkg::item_t head_item;

  amcp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .cfg  (cfg),
    .full (full),
    .push (push),
    .item (in_item)
  );

  amcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_item    (in_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head_item)
  );

  amcp_back #(
    .VALUE_CHAR_LIMIT (VALUE_CHAR_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head_item),
    .pop        (pop),
    .req        (req)
  );

endmodule

// ===== rtl/core/amcp_checker.sv =====
`timescale 1ns / 1ps

module amcp_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input amcp_pkg::request_t req_data
);

  // hold a stalled request
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req_data))
    else $error("request changed while stalled");

  a_not_found_clear: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_data.axis_found |->
      req_data.axis_letter == 8'd0 && req_data.parameter_code == 4'd0 &&
      req_data.value_magnitude == '0 && !req_data.value_negative)
    else $error("unknown-axis request carries fields");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> req_data.command_code >= 3'd1 && req_data.command_code <= 3'd4 &&
      req_data.parameter_code <= 4'd9 && req_data.value_magnitude <= amcp_pkg::MAG_MAX)
    else $error("request field out of range");

  a_found_letter: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_data.axis_found |->
      req_data.axis_letter >= amcp_pkg::CH_UPPER_A &&
      req_data.axis_letter <= amcp_pkg::CH_UPPER_Z)
    else $error("found axis is not an upper-case letter");

  a_reset_idle: assert property (@(posedge clk) rst |=> !req_valid)
    else $error("request valid after reset");

endmodule

bind ascii_motion_command_parser_top amcp_checker u_amcp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_data  (req.data)
);

// ===== tb/sv/ascii_motion_command_parser_checker.sv =====
`timescale 1ns / 1ps

module ascii_motion_command_parser_checker
  import amcp_pkg::*;
#(
  parameter int VALUE_CHAR_LIMIT = VALUE_CHAR_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  input  logic      rx_ready,
  input  rx_item_t  rx_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_word_t cfg_data,
  input  logic      req_valid,
  input  logic      req_ready,
  input  request_t  req_data,
  output int        fail_count,
  output int        pending_count,
  output int        request_count
);

  typedef enum logic [1:0] {
    FIELD_COMMAND, FIELD_AXIS, FIELD_PARAM, FIELD_VALUE
  } field_e;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_ADD, CMD_GET, CMD_SET, CMD_RST
  } command_e;

  typedef enum logic [3:0] {
    PAR_NONE, PAR_ALL, PAR_TARGET, PAR_CURRENT, PAR_MIN_SPS, PAR_MAX_SPS,
    PAR_CUR_SPS, PAR_ACC_SPS, PAR_PRESCALER, PAR_STATUS
  } parameter_e;

  localparam int CMD_COUNT = 5;
  localparam int PAR_COUNT = 10;

  // parser state
  logic [AXIS_W-1:0] axis_mask;
  field_e            fld;
  int                pos;
  logic [CAND_W-1:0] cand;
  command_e          cmd;
  logic [7:0]        axis;
  parameter_e        par;
  logic [MAG_W-1:0]  mag;
  logic              neg;

  request_t pending_requests[$];

  initial begin
    fail_count    = 0;
    request_count = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 30)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [MAG_W-1:0] got,
                             input logic [MAG_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("request %0d %s got %0d want %0d",
                                request_count, name, got, want));
  endtask

  // text is right-justified: last character in the low byte
  function automatic void keyword(input bit is_par, input int k,
                                  output logic [8*KW_MAXLEN-1:0] text, output int len);
    text = '0;
    len  = 0;
    if (!is_par) begin
      case (command_e'(k))
        CMD_ADD:   begin text = "ADD";   len = 3; end
        CMD_GET:   begin text = "GET";   len = 3; end
        CMD_SET:   begin text = "SET";   len = 3; end
        CMD_RST:   begin text = "RESET"; len = 5; end
        default:   ;
      endcase
    end else begin
      case (parameter_e'(k))
        PAR_ALL:       begin text = "ALL";             len = 3;  end
        PAR_TARGET:    begin text = "TARGETPOSITION";  len = 14; end
        PAR_CURRENT:   begin text = "CURRENTPOSITION"; len = 15; end
        PAR_MIN_SPS:   begin text = "MINSPS";          len = 6;  end
        PAR_MAX_SPS:   begin text = "MAXSPS";          len = 6;  end
        PAR_CUR_SPS:   begin text = "CURRENTSPS";      len = 10; end
        PAR_ACC_SPS:   begin text = "ACCSPS";          len = 6;  end
        PAR_PRESCALER: begin text = "ACCPRESCALER";    len = 12; end
        PAR_STATUS:    begin text = "STATUS";          len = 6;  end
        default:       ;
      endcase
    end
  endfunction

  // drop the candidates that do not fit ch at idx; return how many are left
  function automatic int narrow_candidates(input bit is_par, input int idx,
                                           input logic [7:0] ch,
                                           output int last, output int last_len);
    logic [8*KW_MAXLEN-1:0] text;
    int len;
    int left;
    bit fits;
    left     = 0;
    last     = 0;
    last_len = 0;
    for (int k = 1; k < (is_par ? PAR_COUNT : CMD_COUNT); k++) begin
      if (cand[k]) begin
        keyword(is_par, k, text, len);
        fits = 1'b0;
        if (len > idx)
          fits = (text[8*(len-1-idx) +: 8] == ch);
        if (fits) begin
          last     = k;
          last_len = len;
          left++;
        end else begin
          cand[k] = 1'b0;
        end
      end
    end
    return left;
  endfunction

  function automatic void clear_request();
    cmd  = CMD_NONE;
    axis = '0;
    par  = PAR_NONE;
    mag  = '0;
    neg  = 1'b0;
    fld  = FIELD_COMMAND;
    pos  = 0;
  endfunction

  function automatic void finish_request();
    request_t r;
    r.command_code    = cmd;
    r.axis_found      = (axis != 8'd0);
    r.axis_letter     = axis;
    r.parameter_code  = par;
    r.value_magnitude = mag;
    r.value_negative  = neg;
    pending_requests.push_back(r);
    clear_request();
  endfunction

  function automatic void command_byte(input logic [7:0] c);
    int last;
    int last_len;
    int left;
    // a broken keyword gets one retry of the same byte from position zero
    for (int pass = 0; pass < 2; pass++) begin
      if (pos == 0)
        cand = CAND_ALL;
      left = narrow_candidates(1'b0, pos, c, last, last_len);
      if (left == 0) begin
        if (pos > 0) begin
          pos = 0;
          continue;
        end
        return;
      end
      if (left == 1 && last_len == pos + 1) begin
        cmd = command_e'(last);
        fld = FIELD_AXIS;
        pos = 0;
      end else begin
        pos++;
      end
      return;
    end
  endfunction

  function automatic void value_byte(input logic [7:0] c);
    logic [MAG_W+3:0] v;
    if (pos == 0) begin
      if (c == ":") begin
        pos = 1;
        return;
      end
      finish_request();
      command_byte(c);
      return;
    end
    if (pos == 1 && (c == "-" || c == "+")) begin
      if (c == "-")
        neg = 1'b1;
      pos = 2;
      return;
    end
    if (c >= "0" && c <= "9" && pos <= VALUE_CHAR_LIMIT) begin
      v   = (MAG_W+4)'(mag) * (MAG_W+4)'(10) + (MAG_W+4)'(c - "0");
      mag = (v > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : v[MAG_W-1:0];
      pos++;
      return;
    end
    finish_request();
    command_byte(c);
  endfunction

  function automatic void param_byte(input logic [7:0] c);
    int last;
    int last_len;
    int left;
    int idx;
    if (pos == 0) begin
      if (c == ".") begin
        cand = CAND_ALL;
        pos  = 1;
        return;
      end
      fld = FIELD_VALUE;
      value_byte(c);
      return;
    end
    idx  = pos - 1;
    left = narrow_candidates(1'b1, idx, c, last, last_len);
    if (left == 1 && last_len == idx + 1) begin
      par = parameter_e'(last);
      fld = FIELD_VALUE;
      pos = 0;
      return;
    end
    if (left == 0) begin
      // keyword broken off: hand the byte to the value field
      fld = FIELD_VALUE;
      pos = 0;
      value_byte(c);
      return;
    end
    pos++;
  endfunction

  function automatic void parse_byte(input logic [7:0] raw);
    logic [7:0] c;
    bit axis_ok;
    c = raw;
    if (c >= "a" && c <= "z")
      c = c - CASE_OFFSET;
    case (fld)
      FIELD_COMMAND: command_byte(c);
      FIELD_AXIS: begin
        axis_ok = 1'b0;
        if (c >= "A" && c <= "Z")
          axis_ok = axis_mask[c - "A"];
        if (axis_ok) begin
          axis = c;
          fld  = FIELD_PARAM;
          pos  = 0;
        end else begin
          finish_request();
          command_byte(c);
        end
      end
      FIELD_PARAM: param_byte(c);
      default:     value_byte(c);
    endcase
  endfunction

  always @(posedge clk) begin
    request_t want;
    if (rst) begin
      axis_mask = AXIS_MASK_RESET;
      cand      = CAND_ALL;
      clear_request();
      pending_requests.delete();
    end else begin
      if (req_valid && req_ready) begin
        request_count++;
        if (pending_requests.size() == 0) begin
          report_mismatch($sformatf("request %0d arrived with none expected",
                                    request_count));
        end else begin
          want = pending_requests.pop_front();
          check_field("command_code", MAG_W'(req_data.command_code),
                      MAG_W'(want.command_code));
          check_field("axis_found", MAG_W'(req_data.axis_found),
                      MAG_W'(want.axis_found));
          check_field("axis_letter", MAG_W'(req_data.axis_letter),
                      MAG_W'(want.axis_letter));
          check_field("parameter_code", MAG_W'(req_data.parameter_code),
                      MAG_W'(want.parameter_code));
          check_field("value_magnitude", req_data.value_magnitude, want.value_magnitude);
          check_field("value_negative", MAG_W'(req_data.value_negative),
                      MAG_W'(want.value_negative));
        end
      end
      if (cfg_valid && cfg_ready)
        axis_mask = cfg_data.axis_letter_mask;
      if (rx_valid && rx_ready)
        parse_byte(rx_data.rx_byte);
    end
    pending_count = pending_requests.size();
  end

endmodule

// ===== tb/sv/ascii_motion_command_parser_top_tb.sv =====
`timescale 1ns / 1ps

module ascii_motion_command_parser_top_tb;
  import amcp_pkg::*;

  localparam int PHASE_BYTES = 110;

  logic clk;
  logic rst;

  amcp_chan_if #(.data_t(rx_item_t))  rx ();
  amcp_chan_if #(.data_t(cfg_word_t)) cfg ();
  amcp_chan_if #(.data_t(request_t))  req ();

  int fail_count;
  int pending_count;
  int request_count;
  int bytes_sent;
  int masks_used;
  bit idle_on;
  logic [AXIS_W-1:0] cur_mask;

  ascii_motion_command_parser_top u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .cfg (cfg),
    .req (req)
  );

  ascii_motion_command_parser_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx.valid),
    .rx_ready      (rx.ready),
    .rx_data       (rx.data),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .cfg_data      (cfg.data),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_data      (req.data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .request_count (request_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d requests still expected", pending_count);
    $display("FAILED: results differ");
    $finish;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    req.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        req.ready <= 1'b0;
        hold--;
      end else begin
        req.ready <= 1'b1;
        if (idle_on)
          hold = pick_gap();
      end
    end
  end

  function automatic string command_text(input int k);
    case (k)
      1:       return "ADD";
      2:       return "GET";
      3:       return "SET";
      default: return "RESET";
    endcase
  endfunction

  function automatic string param_text(input int k);
    case (k)
      1:       return "ALL";
      2:       return "TARGETPOSITION";
      3:       return "CURRENTPOSITION";
      4:       return "MINSPS";
      5:       return "MAXSPS";
      6:       return "CURRENTSPS";
      7:       return "ACCSPS";
      8:       return "ACCPRESCALER";
      default: return "STATUS";
    endcase
  endfunction

  // call at a rising edge; returns at the edge where the byte is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.data  <= b;
    do @(negedge clk); while (!rx.ready);
    @(posedge clk);
    bytes_sent++;
  endtask

  // letters go out in either case
  task automatic send_letter(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
      ch = ch + CASE_OFFSET;
    send_byte(ch);
  endtask

  task automatic send_word(input string w, input int n);
    for (int i = 0; i < n; i++)
      send_letter(w[i]);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  task automatic send_request();
    string w;
    int n;
    int r;
    int k;
    int digits;
    w = command_text($urandom_range(1, 4));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w.len()) : w.len();
    send_word(w, n);
    if (n < w.len())
      return;
    r = $urandom_range(0, 9);
    if (r < 7 && cur_mask != '0) begin
      do k = $urandom_range(0, AXIS_W - 1); while (!cur_mask[k]);
      send_letter(8'("A" + k));
    end else if (r < 9) begin
      send_letter(8'("A" + $urandom_range(0, AXIS_W - 1)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      send_byte(".");
      w = param_text($urandom_range(1, 9));
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w.len()) : w.len();
      send_word(w, n);
    end else if (r == 6) begin
      send_byte(".");
    end
    if ($urandom_range(0, 2) != 0) begin
      send_byte(":");
      r = $urandom_range(0, 3);
      if (r == 0)
        send_byte("-");
      else if (r == 1)
        send_byte("+");
      digits = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(10, 14);
      for (int i = 0; i < digits; i++)
        send_byte(8'("0" + $urandom_range(0, 9)));
    end
  endtask

  // drop valid, wait for every expected request, then let the queue empty
  task automatic drain();
    rx.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mask(input logic [AXIS_W-1:0] m);
    cfg.valid <= 1'b1;
    cfg.data  <= m;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    cfg.valid <= 1'b0;
    cur_mask = m;
    masks_used++;
  endtask

  task automatic run_phase(input logic [AXIS_W-1:0] m, input bit gaps);
    int start;
    write_mask(m);
    idle_on = gaps;
    start   = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      send_request();
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  initial begin
    rst        <= 1'b1;
    rx.valid   <= 1'b0;
    rx.data    <= '0;
    cfg.valid  <= 1'b0;
    cfg.data   <= '0;
    idle_on    = 1'b0;
    cur_mask   = AXIS_MASK_RESET;
    bytes_sent = 0;
    masks_used = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: junk at command start, broken command, axis missing,
    // sign without digits, parameter without dot
    idle_on = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("adGETx.all:-");
    send_text("SETq");
    send_text("RESETZ:9");
    send_text("ADDY");
    send_text("g");
    drain();

    run_phase({AXIS_W{1'b1}}, 1'b0);
    run_phase('0, 1'b1);
    run_phase(AXIS_W'($urandom()), 1'b1);
    run_phase(AXIS_W'(1), 1'b1);
    run_phase(AXIS_W'(1) << (AXIS_W - 1), $urandom_range(0, 1));
    run_phase(AXIS_W'($urandom()), 1'b1);
    run_phase(AXIS_MASK_RESET, 1'b1);

    repeat (10) @(posedge clk);
    $display("Run covered %0d bytes under %0d axis masks; %0d requests compared.",
             bytes_sent, masks_used, request_count);
    if (fail_count == 0 && pending_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
